// ----- rtl/ssm_pkg.sv -----
// package for the two-way sorted merge block
// shared types, opcodes and register codes; no dependencies
`timescale 1ns / 1ps

package ssm_pkg;

  localparam logic [1:0] OP_APPEND_A = 2'd0;
  localparam logic [1:0] OP_APPEND_B = 2'd1;
  localparam logic [1:0] OP_RUN      = 2'd2;

  localparam logic REG_MODE = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic append_a;
    logic append_b;
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic need_out;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/ssm_in_if.sv -----
// request channel interface for the sorted merge block
// valid/ready handshake with opcode and value payload
`timescale 1ns / 1ps

interface ssm_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  opcode;
  logic signed [31:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

// ----- rtl/ssm_out_if.sv -----
// result channel interface for the sorted merge block
// valid/ready handshake with merged value and flags
`timescale 1ns / 1ps

interface ssm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_value;
  logic               last;
  logic               empty_res;
  logic               overflow;

  modport source (output valid, output out_value, output last, output empty_res,
                  output overflow, input ready);
  modport sink   (input valid, input out_value, input last, input empty_res,
                  input overflow, output ready);
endinterface

// ----- rtl/ssm_ctrl.sv -----
// controller state machine for the sorted merge block
// uses ssm_pkg; drives datapath commands from request and status
`timescale 1ns / 1ps

module ssm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [1:0]       opcode,
  output logic             req_ready,
  input  ssm_pkg::status_t status,
  output ssm_pkg::cmd_t    cmd
);
  import ssm_pkg::*;

  state_t state, state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid && opcode == OP_RUN) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (status.walk_done) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    cmd       = '0;
    accept    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready    = 1'b1;
        accept       = req_valid;
        cmd.append_a = accept && opcode == OP_APPEND_A;
        cmd.append_b = accept && opcode == OP_APPEND_B;
        cmd.start    = accept && opcode == OP_RUN;
      end
      ST_WALK: begin
        cmd.step = !status.walk_done && (!status.need_out || status.out_free);
      end
      ST_FLUSH: begin
        cmd.finish = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/ssm_datapath.sv -----
// datapath for the sorted merge block: buffers, walk pointers, hold and output registers
// uses ssm_pkg; commanded by ssm_ctrl
`timescale 1ns / 1ps

module ssm_datapath #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               mode,
  input  logic signed [31:0] value,
  input  ssm_pkg::cmd_t      cmd,
  output ssm_pkg::status_t   status,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic               out_last,
  output logic               out_empty,
  output logic               out_overflow
);
  import ssm_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_WIDTH-1:0] buf_a [DEPTH];
  logic [DATA_WIDTH-1:0] buf_b [DEPTH];
  logic [CW-1:0]         count_a, count_b, ia, ib;
  logic                  dropped;
  logic [DATA_WIDTH-1:0] prev, hold;
  logic                  have_prev, hold_valid;
  logic [DATA_WIDTH-1:0] wdata, head_a, head_b, pick;
  logic                  a_ok, b_ok, take_a, take_b, both_drop, suppress, emit, out_free;

  assign wdata  = DATA_WIDTH'($unsigned(value));
  assign a_ok   = ia < count_a;
  assign b_ok   = ib < count_b;
  assign head_a = buf_a[ia[AW-1:0]];
  assign head_b = buf_b[ib[AW-1:0]];

  always_comb begin
    take_a    = 1'b0;
    take_b    = 1'b0;
    both_drop = 1'b0;
    if (a_ok && b_ok) begin
      if ($signed(head_a) < $signed(head_b)) begin
        take_a = 1'b1;
      end else if (mode && head_a == head_b) begin
        both_drop = 1'b1;
      end else begin
        take_b = 1'b1;
      end
    end else if (b_ok) begin
      take_b = 1'b1;
    end else begin
      take_a = 1'b1;
    end
  end

  assign pick     = take_a ? head_a : head_b;
  assign suppress = mode && have_prev && prev == pick;
  assign emit     = !both_drop && !suppress;
  assign out_free = !out_valid || out_ready;

  assign status.walk_done = !a_ok && !b_ok;
  assign status.need_out  = emit && hold_valid;
  assign status.out_free  = out_free;

  // buffers, no reset
  always_ff @(posedge clk) begin
    if (cmd.append_a && count_a < CW'(DEPTH)) buf_a[count_a[AW-1:0]] <= wdata;
    if (cmd.append_b && count_b < CW'(DEPTH)) buf_b[count_b[AW-1:0]] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a    <= '0;
      count_b    <= '0;
      dropped    <= 1'b0;
      ia         <= '0;
      ib         <= '0;
      have_prev  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (cmd.append_a) begin
        if (count_a < CW'(DEPTH)) count_a <= count_a + CW'(1);
        else dropped <= 1'b1;
      end
      if (cmd.append_b) begin
        if (count_b < CW'(DEPTH)) count_b <= count_b + CW'(1);
        else dropped <= 1'b1;
      end
      if (cmd.start) begin
        ia         <= '0;
        ib         <= '0;
        have_prev  <= 1'b0;
        hold_valid <= 1'b0;
      end
      if (cmd.step) begin
        if (take_a || both_drop) ia <= ia + CW'(1);
        if (take_b || both_drop) ib <= ib + CW'(1);
        if (both_drop || emit) have_prev <= 1'b1;
        if (emit) hold_valid <= 1'b1;
      end
      if (cmd.finish) begin
        count_a    <= '0;
        count_b    <= '0;
        ia         <= '0;
        ib         <= '0;
        dropped    <= 1'b0;
        hold_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      if (both_drop) prev <= head_a;
      else if (emit) prev <= pick;
      if (emit) hold <= pick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish || (cmd.step && emit && hold_valid)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value    <= hold_valid ? 32'(hold) : '0;
      out_last     <= 1'b1;
      out_empty    <= !hold_valid;
      out_overflow <= dropped;
    end else if (cmd.step && emit && hold_valid) begin
      out_value    <= 32'(hold);
      out_last     <= 1'b0;
      out_empty    <= 1'b0;
      out_overflow <= dropped;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    ia <= count_a && ib <= count_b)
    else $error("walk pointer beyond fill count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_a <= CW'(DEPTH) && count_b <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && emit && hold_valid) || cmd.finish |-> out_free)
    else $error("output register loaded while occupied");

  a_clear_after_run: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> count_a == '0 && count_b == '0 && !dropped)
    else $error("buffers not cleared after run");
`endif

endmodule

// ----- rtl/sorted_sequence_merge_top.sv -----
// two-way sorted merge, top level: config register, controller and datapath
// throughput: one walk step per cycle while the walk is not stalled, results leave at up to one per cycle
// the walk stalls only when a finished result is held, the step would emit another and the output register is full
// reset (rst, synchronous): clears counts, overflow flag, mode and output valid
`timescale 1ns / 1ps

module sorted_sequence_merge_top #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  ssm_in_if.sink      request,
  ssm_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ssm_pkg::*;

  logic    mode;
  cmd_t    cmd;
  status_t status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? {31'b0, mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_MODE) begin
      mode <= pwdata[0];
    end
  end

  ssm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .opcode    (request.opcode),
    .req_ready (request.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ssm_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .value        (request.value),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (result.ready),
    .out_valid    (result.valid),
    .out_value    (result.out_value),
    .out_last     (result.last),
    .out_empty    (result.empty_res),
    .out_overflow (result.overflow)
  );

endmodule
